[design/queue_from_two_stacks_core_assert.svh]
// ----------------------------------------------------------------------------
// queue_from_two_stacks_core assertion macros
// Concurrent assertion wrappers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUEUE_FROM_TWO_STACKS_CORE_ASSERT_SVH
`define QUEUE_FROM_TWO_STACKS_CORE_ASSERT_SVH

// same-cycle implication
`define QFTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QFTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[design/qfts_pkg.sv]
// ----------------------------------------------------------------------------
// qfts_pkg
// Command and status codes and sequencer states of the two-stack queue.
// ----------------------------------------------------------------------------
package qfts_pkg;

    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_PEEK    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_XRD,
        S_XWR,
        S_RD,
        S_RDWAIT
    } t_state;

endpackage

[design/qfts_ram.sv]
// ----------------------------------------------------------------------------
// qfts_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module qfts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/queue_from_two_stacks_core.sv]
// ----------------------------------------------------------------------------
// queue_from_two_stacks_core
// FIFO queue built from an arrival stack and a departure stack in RAM.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel: tuser carries the command
// (enqueue, dequeue, peek), tdata the value to enqueue. Each item gives
// exactly one result on the m_axis channel: tuser carries the status
// (ok, queue empty, input stack full), tdata the value, the entry count
// and the empty flag.
// An enqueue (stored or refused), an unused command or an empty
// dequeue/peek finishes in the accept cycle: its result is registered and
// shows in the next cycle. A dequeue or peek with a non-empty departure
// stack waits in S_RDWAIT for the registered read of the departure RAM.
// When the departure stack is empty, every arrival entry is first moved
// across (arrival RAM read in S_XRD, then departure RAM write in S_XWR),
// and the item then passes through S_RD and S_RDWAIT.
// The block takes an item only in the idle state and while the output
// register is free or being taken; a stalled receiver holds the result and
// holds off the next item. Reset empties both stacks at once; RAM contents
// are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module queue_from_two_stacks_core #(
    parameter int STACK_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] data_in
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // [31:0] data_out, [40:32] entry_count,
                                         // [41] is_empty, [47:42] zero
    output logic [1:0]  o_m_axis_tuser   // [1:0] status
);

    import qfts_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int TW = $clog2(2 * STACK_DEPTH + 1);
    localparam int CW = (TW > 9) ? TW : 9;

    t_state          r_state, n_state;
    logic [DW-1:0]   r_ad, n_ad;
    logic [DW-1:0]   r_dd, n_dd;
    logic [CW-1:0]   r_total, n_total;
    logic            r_is_deq, n_is_deq;
    logic            r_out_valid, n_out_valid;
    logic [31:0]     r_out_data, n_out_data;
    logic [1:0]      r_out_status, n_out_status;
    logic [8:0]      r_out_count, n_out_count;
    logic            r_out_empty, n_out_empty;

    logic            accept;
    logic            load;
    logic [DW-1:0]   ad_m1, dd_m1;
    logic [CW-1:0]   depth_sum;

    logic            arr_we;
    logic [AW-1:0]   arr_raddr;
    logic [31:0]     arr_rdata;
    logic            dep_we;
    logic [AW-1:0]   dep_raddr;
    logic [31:0]     dep_rdata;

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign ad_m1           = r_ad - DW'(1);
    assign dd_m1           = r_dd - DW'(1);
    assign arr_raddr       = ad_m1[AW-1:0];
    assign dep_raddr       = dd_m1[AW-1:0];
    assign depth_sum       = CW'(r_ad) + CW'(r_dd);

    qfts_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_arrival (
        .i_clk   (i_clk),
        .i_we    (arr_we),
        .i_waddr (r_ad[AW-1:0]),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (arr_raddr),
        .o_rdata (arr_rdata)
    );

    qfts_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_departure (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (r_dd[AW-1:0]),
        .i_wdata (arr_rdata),
        .i_raddr (dep_raddr),
        .o_rdata (dep_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ad        <= '0;
            r_dd        <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ad        <= n_ad;
            r_dd        <= n_dd;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_deq <= n_is_deq;
        if (load) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
            r_out_count  <= n_out_count;
            r_out_empty  <= n_out_empty;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_ad         = r_ad;
        n_dd         = r_dd;
        n_total      = r_total;
        n_is_deq     = r_is_deq;
        load         = 1'b0;
        n_out_data   = '0;
        n_out_status = ST_OK;
        arr_we       = 1'b0;
        dep_we       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_is_deq = (i_s_axis_tuser == CMD_DEQUEUE);
                    unique case (i_s_axis_tuser)
                        CMD_ENQUEUE: begin
                            load = 1'b1;
                            if (r_ad == DW'(STACK_DEPTH)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                arr_we  = 1'b1;
                                n_ad    = r_ad + DW'(1);
                                n_total = r_total + CW'(1);
                            end
                        end
                        CMD_DEQUEUE, CMD_PEEK: begin
                            priority if (r_ad == '0 && r_dd == '0) begin
                                load         = 1'b1;
                                n_out_status = ST_EMPTY;
                                n_out_data   = EMPTY_VALUE;
                            end else if (r_dd == '0) begin
                                n_state = S_XRD;
                            end else begin
                                // departure top read is issued now
                                n_state = S_RDWAIT;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_XRD: begin
                // pop the arrival top; data lands next cycle
                n_ad    = ad_m1;
                n_state = S_XWR;
            end
            S_XWR: begin
                dep_we = 1'b1;
                n_dd   = r_dd + DW'(1);
                if (r_ad == '0 || n_dd == DW'(STACK_DEPTH)) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_XRD;
                end
            end
            S_RD: begin
                n_state = S_RDWAIT;
            end
            S_RDWAIT: begin
                load       = 1'b1;
                n_out_data = dep_rdata;
                if (r_is_deq) begin
                    n_dd    = dd_m1;
                    n_total = r_total - CW'(1);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_count = n_total[8:0];
        n_out_empty = (n_total == '0);

        priority if (load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_empty, r_out_count, r_out_data};
    assign o_m_axis_tuser  = r_out_status;

`include "queue_from_two_stacks_core_assert.svh"

    // an entry in transit between the stacks is counted by neither depth
    `QFTS_ASSERT_NOW(a_ready_only_idle, o_s_axis_tready, r_state == S_IDLE, "ready outside idle")
    `QFTS_ASSERT_NOW(a_total_matches, r_state != S_XWR, r_total == depth_sum, "total off")
    `QFTS_ASSERT_NOW(a_arr_bounds, 1'b1, r_ad <= DW'(STACK_DEPTH), "arrival depth overflow")
    `QFTS_ASSERT_NOW(a_dep_bounds, 1'b1, r_dd <= DW'(STACK_DEPTH), "departure depth overflow")
    `QFTS_ASSERT_NEXT(a_result_after_read, r_state == S_RDWAIT,
                      o_m_axis_tvalid && r_state == S_IDLE, "read result not loaded")

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-stack queue core. A directed table covers
// the empty, extreme and unused-command cases; a random phase then fills the
// arrival stack to refusal and drains it through the departure stack.
// Every accepted item runs through a local model of both stacks, and each
// result is checked against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import qfts_pkg::*;

    localparam int          STACK_DEPTH  = 128;
    localparam logic [1:0]  CMD_NOP      = 2'd3;
    localparam int          RANDOM_ITEMS = 2000;
    localparam int          TAIL_CYCLES  = 2 * STACK_DEPTH + 50;
    localparam int          CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic [8:0]  count;
        logic        empty;
    } t_q_result;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] data;
        logic        typed;
        t_q_result   exp;
    } t_dir_row;

    localparam int DIR_ROWS = 19;

    // typed rows carry their expected result; the others take theirs from the model
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{CMD_DEQUEUE, 32'h1234_5678, 1'b1, '{EMPTY_VALUE, ST_EMPTY, 9'd0, 1'b1}},
        '{CMD_PEEK,    32'hFFFF_FFFF, 1'b1, '{EMPTY_VALUE, ST_EMPTY, 9'd0, 1'b1}},
        '{CMD_NOP,     32'hA5A5_A5A5, 1'b1, '{32'd0,       ST_OK,    9'd0, 1'b1}},
        '{CMD_ENQUEUE, 32'h7FFF_FFFF, 1'b1, '{32'd0,       ST_OK,    9'd1, 1'b0}},
        '{CMD_ENQUEUE, 32'h8000_0000, 1'b1, '{32'd0,       ST_OK,    9'd2, 1'b0}},
        '{CMD_ENQUEUE, 32'hFFFF_FFFF, 1'b1, '{32'd0,       ST_OK,    9'd3, 1'b0}},
        '{CMD_ENQUEUE, 32'h0000_0000, 1'b1, '{32'd0,       ST_OK,    9'd4, 1'b0}},
        '{CMD_PEEK,    32'h0,         1'b1, '{32'h7FFF_FFFF, ST_OK,  9'd4, 1'b0}},
        '{CMD_DEQUEUE, 32'h0,         1'b1, '{32'h7FFF_FFFF, ST_OK,  9'd3, 1'b0}},
        '{CMD_ENQUEUE, 32'h0000_0005, 1'b0, '0},
        '{CMD_NOP,     32'h5A5A_5A5A, 1'b0, '0},
        '{CMD_DEQUEUE, 32'h0,         1'b0, '0},
        '{CMD_DEQUEUE, 32'h0,         1'b0, '0},
        '{CMD_DEQUEUE, 32'h0,         1'b0, '0},
        '{CMD_PEEK,    32'h0,         1'b0, '0},
        '{CMD_DEQUEUE, 32'h0,         1'b1, '{32'd5,       ST_OK,    9'd0, 1'b1}},
        '{CMD_DEQUEUE, 32'h0,         1'b1, '{EMPTY_VALUE, ST_EMPTY, 9'd0, 1'b1}},
        '{CMD_PEEK,    32'h0,         1'b1, '{EMPTY_VALUE, ST_EMPTY, 9'd0, 1'b1}},
        '{CMD_NOP,     32'hFFFF_FFFF, 1'b1, '{32'd0,       ST_OK,    9'd0, 1'b1}}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // [31:0] data_in
    logic [1:0]  i_s_axis_tuser;   // [1:0] command
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;   // [31:0] data_out, [40:32] entry_count,
                                   // [41] is_empty, [47:42] zero
    logic [1:0]  o_m_axis_tuser;   // [1:0] status

    queue_from_two_stacks_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // model of the two stacks
    logic [31:0] arrival_mem   [STACK_DEPTH];
    logic [31:0] departure_mem [STACK_DEPTH];
    int          arrival_top;
    int          departure_top;
    int          held_total;

    t_q_result   pending_results [$];
    int          mismatch_count;
    int          burst_left;
    logic        row_typed;
    t_q_result   row_exp;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_q_result predict_queue_op(input logic [1:0] cmd,
                                                   input logic [31:0] data);
        t_q_result r;
        r = '{32'd0, ST_OK, 9'd0, 1'b0};
        if (cmd == CMD_ENQUEUE) begin
            if (arrival_top >= STACK_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                arrival_mem[arrival_top] = data;
                arrival_top++;
                held_total++;
            end
        end else if (cmd == CMD_DEQUEUE || cmd == CMD_PEEK) begin
            if (arrival_top == 0 && departure_top == 0) begin
                r.status = ST_EMPTY;
                r.value  = EMPTY_VALUE;
            end else begin
                // refill reverses the arrival order
                if (departure_top == 0) begin
                    while (arrival_top > 0 && departure_top < STACK_DEPTH) begin
                        arrival_top--;
                        departure_mem[departure_top] = arrival_mem[arrival_top];
                        departure_top++;
                    end
                end
                r.value = departure_mem[departure_top - 1];
                if (cmd == CMD_DEQUEUE) begin
                    departure_top--;
                    held_total--;
                end
            end
        end
        r.count = held_total[8:0];
        r.empty = (held_total == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // predict on every accepted input item
    always @(posedge i_clk) begin
        t_q_result p;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            p = predict_queue_op(i_s_axis_tuser, i_s_axis_tdata);
            pending_results.push_back(row_typed ? row_exp : p);
        end
    end

    // check every accepted result item
    always @(posedge i_clk) begin
        t_q_result e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result item with no prediction pending");
            end else begin
                e = pending_results.pop_front();
                if (o_m_axis_tdata[31:0] != e.value)
                    report_mismatch($sformatf("data_out %h, want %h",
                                              o_m_axis_tdata[31:0], e.value));
                if (o_m_axis_tuser != e.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_m_axis_tuser, e.status));
                if (o_m_axis_tdata[40:32] != e.count)
                    report_mismatch($sformatf("entry_count %0d, want %0d",
                                              o_m_axis_tdata[40:32], e.count));
                if (o_m_axis_tdata[41] != e.empty)
                    report_mismatch($sformatf("is_empty %0b, want %0b",
                                              o_m_axis_tdata[41], e.empty));
                if (o_m_axis_tdata[47:42] != 6'd0)
                    report_mismatch($sformatf("pad bits %h, want 0",
                                              o_m_axis_tdata[47:42]));
            end
        end
    end

    // receiver: alternate ready and stall stretches, with long clean runs
    int rx_left;
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            if (i_m_axis_tready) begin
                i_m_axis_tready <= 1'b0;
                rx_left         <= $urandom_range(1, 6);
            end else begin
                i_m_axis_tready <= 1'b1;
                rx_left         <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                               : $urandom_range(1, 10);
            end
        end else begin
            rx_left <= rx_left - 1;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [31:0] data,
                             input logic typed, input t_q_result exp);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = cmd;
        i_s_axis_tdata  = data;
        row_typed       = typed;
        row_exp         = exp;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // hold off the sender until every pending result has come back
    task automatic wait_drained();
        i_s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_mixed_cmd();
        int r;
        r = $urandom_range(0, 15);
        if (r < 7)  return CMD_ENQUEUE;
        if (r < 12) return CMD_DEQUEUE;
        if (r < 15) return CMD_PEEK;
        return CMD_NOP;
    endfunction

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("queue_from_two_stacks_core test failed");
        $finish;
    end

    initial begin
        int sent;
        int len;
        int mode;
        bit drained_mid;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_ENQUEUE;
        i_m_axis_tready = 1'b0;
        rx_left         = 0;
        arrival_top     = 0;
        departure_top   = 0;
        held_total      = 0;
        mismatch_count  = 0;
        burst_left      = 0;
        row_typed       = 1'b0;
        row_exp         = '0;
        drained_mid     = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].typed,
                      dir_rows[i].exp);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 9);
            case (mode)
                0, 1, 2: begin
                    // fill, often past the arrival limit
                    len = $urandom_range(1, STACK_DEPTH + 12);
                    repeat (len) send_item(CMD_ENQUEUE, pick_value(), 1'b0, '0);
                end
                3, 4: begin
                    len = $urandom_range(1, STACK_DEPTH + 12);
                    repeat (len) send_item(CMD_DEQUEUE, $urandom, 1'b0, '0);
                end
                5, 6, 7: begin
                    len = $urandom_range(1, 40);
                    repeat (len) send_item(pick_mixed_cmd(), pick_value(), 1'b0, '0);
                end
                8: begin
                    len = $urandom_range(1, 4);
                    repeat (len) send_item(CMD_PEEK, $urandom, 1'b0, '0);
                end
                default: begin
                    wait_drained();
                    len = 1;
                    send_item(($urandom_range(0, 1) != 0) ? CMD_NOP : CMD_PEEK,
                              $urandom, 1'b0, '0);
                end
            endcase
            sent += len;
            if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
                drained_mid = 1'b1;
                wait_drained();
            end
        end
        i_s_axis_tvalid = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("queue_from_two_stacks_core test passed");
        end else begin
            $display("queue_from_two_stacks_core test failed");
        end
        $finish;
    end

endmodule

[queue_from_two_stacks_core.f]
+incdir+design
design/qfts_pkg.sv
design/qfts_ram.sv
design/queue_from_two_stacks_core.sv
tb/tb_top.sv
